@@ design/itcf_pkg.sv @@
package itcf_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF    = 20;
	localparam int CORDIC_MAX          = 30;
	// CORDIC angle accumulator: degrees, 32 fraction bits
	localparam int ZW                  = 42;
	// shared subtract/compare width: root remainder is 62 bits
	localparam int ALU_W               = 63;

	localparam logic [15:0] ALPHA_RESET = 16'd64225;
	localparam logic [1:0]  RANGE_RESET = 2'd0;
	// 0.9995 in Q0.24 and its complement
	localparam logic [23:0] YAW_KEEP    = 24'd16768827;
	localparam logic [23:0] YAW_REST    = 24'd8389;

	localparam logic [0:0] REG_ALPHA = 1'b0;
	localparam logic [0:0] REG_RANGE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_ROOT_LD,
		ST_ROOT,
		ST_CORD_LD,
		ST_CORD,
		ST_GMUL,
		ST_DIV_LD,
		ST_DIV,
		ST_BLEND,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ANG_ROLL,
		ANG_PITCH,
		ANG_YAW
	} ang_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             ge;
		logic [ALU_W-1:0] diff;
	} alu_res_t;

	typedef logic signed [ZW-1:0] atan_tab_t [CORDIC_MAX];

	// range factor times 1000 ms
	function automatic logic [16:0] gyro_divisor(input logic [1:0] range);
		logic [16:0] d;
		case (range)
			2'd0:    d = 17'd131000;
			2'd1:    d = 17'd65500;
			2'd2:    d = 17'd32800;
			default: d = 17'd16400;
		endcase
		return d;
	endfunction

	// shift-and-subtract quotient, evaluated at elaboration only
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in degrees with 32 fraction bits, odd power series for i >= 2
	function automatic atan_tab_t atan_table();
		atan_tab_t         t;
		longint unsigned   deg;
		longint unsigned   term;
		longint            acc;
		int                n;
		int                sh;
		deg = 64'd246083499208;
		for (int i = 0; i < CORDIC_MAX; i++) begin
			if (i == 0) begin
				t[i] = ZW'(64'd193273528320);
			end else if (i == 1) begin
				t[i] = ZW'(64'd114096026022);
			end else begin
				acc = 0;
				for (int k = 0; k < 32; k++) begin
					n  = 2 * k + 1;
					sh = i * n;
					if (sh < 64) begin
						term = udiv64(deg >> sh, 64'(n));
						if (k[0] == 1'b1)
							acc = acc - longint'(term);
						else
							acc = acc + longint'(term);
					end
				end
				t[i] = ZW'(acc);
			end
		end
		return t;
	endfunction

endpackage

@@ design/itcf_addsub.sv @@
module itcf_addsub (
	input  itcf_pkg::alu_req_t req,
	output itcf_pkg::alu_res_t res
);
	import itcf_pkg::*;

	logic [ALU_W:0] wide;

	always_comb begin
		wide     = {1'b0, req.a} - {1'b0, req.b};
		res.ge   = ~wide[ALU_W];
		res.diff = wide[ALU_W-1:0];
	end

endmodule

@@ design/imu_tilt_complementary_filter.sv @@
// channel  | dir | ports                      | payload (low bit up)
// ---------+-----+----------------------------+---------------------------------------------
// sample   | in  | s_tvalid s_tready s_tdata  | accel_x y z, gyro_x y z, elapsed_ms
// result   | out | m_tvalid m_tready m_tdata  | fused r/p/y, gyro r/p/y, tilt r/p/y
//          |     | m_tuser                    | yaw_valid
// config   | in  | cfg_we cfg_index cfg_wdata | 0 blend_alpha, 1 gyro_fs_sel
//
// The work on one sample, from transfer to transfer, is shortened when a root or a tilt angle
// is skipped. The time is set by three serial parts: a bit-serial root (32 steps) and the
// bit-serial gyro divide (32 + ANGLE_FRAC_BITS steps), both on one shared compare/subtract
// unit, and the CORDIC (CORDIC_STEPS) on its own adders, three times each.
// s_tready is high only while idle; a finished result waits in the output register
// and the next sample is taken while it waits. Reset clears all filter state.
module imu_tilt_complementary_filter #(
	parameter int ANGLE_FRAC_BITS = itcf_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = itcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fused_roll, fused_pitch, fused_yaw, gyro_roll, gyro_pitch, gyro_yaw,
	// tilt_roll, tilt_pitch, tilt_yaw, zero pad
	output logic [271:0] m_tdata,
	// yaw_valid
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_wdata
);
	import itcf_pkg::*;

	localparam int F   = ANGLE_FRAC_BITS;
	localparam int NW  = 32 + F;
	localparam int DXW = NW + 1;
	localparam int SW  = NW + 2;
	localparam int CW  = $clog2(NW);
	localparam int XW  = 35;
	localparam int EPS = ((1 << F) + 500) / 1000;
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) << (31 - F);
	localparam atan_tab_t ATAN = atan_table();
	localparam logic [CW-1:0] CORD_LAST = CW'(CORDIC_STEPS - 1);
	localparam logic [CW-1:0] ROOT_LAST = CW'(31);
	localparam logic [CW-1:0] DIV_LAST  = CW'(NW - 1);
	localparam logic [CW-1:0] SQR_LAST  = CW'(2);
	localparam logic [CW-1:0] BLEND_LAST = CW'(6);
	localparam logic signed [SW-1:0] SMAX = SW'(32'sh7fff_ffff);
	localparam logic signed [SW-1:0] SMIN = SW'(32'sh8000_0000);

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		if (v > SMAX)
			return 32'sh7fff_ffff;
		else if (v < SMIN)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	ang_t ang_q;
	logic [1:0] axis_q;

	logic [15:0] alpha_q;
	logic [1:0]  grange_q;

	logic signed [15:0] acc_in_q [3];
	logic signed [15:0] gyr_q [3];
	logic [15:0] ms_q;
	logic valid_q;
	logic [30:0] sq_q [3];

	logic [61:0] n_q;
	logic [62:0] res_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [31:0] roll_q, pitch_q, held_q;

	logic signed [32:0] p_q;
	logic [NW-1:0] num_q, quo_q;
	logic [17:0] rem_q;
	logic neg_q;

	logic signed [31:0] integ_q [3];
	logic signed [31:0] fused_q [3];
	logic signed [31:0] pred_q [3];
	logic signed [59:0] acc_q;

	logic [271:0] m_tdata_q;
	logic         m_tuser_q;
	logic         m_tvalid_q;

	alu_req_t alu_req;
	alu_res_t alu_res;

	itcf_addsub u_addsub (
		.req(alu_req),
		.res(alu_res)
	);

	logic signed [24:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [57:0] prod;
	logic acc_clr;

	assign prod = mul_a * mul_b;

	// shared datapath terms
	logic [31:0] s_sel;
	logic skip;
	logic [62:0] bitv;
	logic [30:0] root;
	logic signed [XW-1:0] xi, yi;
	logic y_zero;
	logic signed [XW-1:0] x_sh, y_sh;
	logic signed [ZW-1:0] z_nxt, z_rnd;
	logic [17:0] r2;
	logic [NW-1:0] q_fin;
	logic signed [DXW-1:0] dx;
	logic [31:0] mag;
	logic signed [59:0] rnd16, rnd24;
	logic signed [31:0] yaw_new;

	always_comb begin
		case (ang_q)
			ANG_ROLL:  s_sel = {1'b0, sq_q[0]} + {1'b0, sq_q[2]};
			ANG_PITCH: s_sel = {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
			default:   s_sel = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
		endcase
		skip = (ang_q == ANG_YAW) ? ~valid_q : (s_sel == 32'd0);

		bitv = 63'(1) << (7'd62 - {1'b0, cnt_q[4:0], 1'b0});
		root = res_q[30:0];

		case (ang_q)
			ANG_ROLL: begin
				xi = XW'({1'b0, root});
				yi = XW'(acc_in_q[1]) <<< 15;
			end
			ANG_PITCH: begin
				xi = XW'({1'b0, root});
				yi = -(XW'(acc_in_q[0]) <<< 15);
			end
			default: begin
				xi = XW'(acc_in_q[2]) <<< 15;
				yi = XW'({1'b0, root});
			end
		endcase
		y_zero = (yi == '0);

		x_sh  = y_q >>> cnt_q;
		y_sh  = x_q >>> cnt_q;
		z_nxt = y_q[XW-1] ? z_q - ATAN[cnt_q[4:0]] : z_q + ATAN[cnt_q[4:0]];
		z_rnd = (z_nxt + Z_HALF) >>> (32 - F);

		r2    = {rem_q[16:0], num_q[NW-1]};
		q_fin = {quo_q[NW-2:0], alu_res.ge};
		dx    = neg_q ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
		mag   = p_q[32] ? 32'(-p_q) : p_q[31:0];

		rnd16 = acc_q + 60'sd32768;
		rnd24 = acc_q + 60'sd8388608;
		if (valid_q)
			yaw_new = rnd24[55:24];
		else if (fused_q[2] > pred_q[2])
			yaw_new = sat32(SW'(pred_q[2]) + SW'(EPS));
		else if (fused_q[2] < pred_q[2])
			yaw_new = sat32(SW'(pred_q[2]) - SW'(EPS));
		else
			yaw_new = fused_q[2];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_SQR;
			ST_SQR:     if (cnt_q == SQR_LAST) state_d = ST_ROOT_LD;
			ST_ROOT_LD: begin
				if (skip)
					state_d = (ang_q == ANG_YAW) ? ST_GMUL : ST_ROOT_LD;
				else
					state_d = ST_ROOT;
			end
			ST_ROOT:    if (cnt_q == ROOT_LAST) state_d = ST_CORD_LD;
			ST_CORD_LD: begin
				if (y_zero)
					state_d = (ang_q == ANG_YAW) ? ST_GMUL : ST_ROOT_LD;
				else
					state_d = ST_CORD;
			end
			ST_CORD: begin
				if (cnt_q == CORD_LAST)
					state_d = (ang_q == ANG_YAW) ? ST_GMUL : ST_ROOT_LD;
			end
			ST_GMUL:    state_d = ST_DIV_LD;
			ST_DIV_LD:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST)
					state_d = (axis_q == 2'd2) ? ST_BLEND : ST_GMUL;
			end
			ST_BLEND:   if (cnt_q == BLEND_LAST) state_d = ST_DONE;
			ST_DONE:    if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, shared unit and multiplier operands
	always_comb begin
		s_tready = 1'b0;
		alu_req.a = '0;
		alu_req.b = '0;
		mul_a = '0;
		mul_b = '0;
		acc_clr = 1'b1;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SQR: begin
				mul_a = 25'(acc_in_q[cnt_q[1:0]]);
				mul_b = 33'(acc_in_q[cnt_q[1:0]]);
			end
			ST_ROOT: begin
				alu_req.a = {1'b0, n_q};
				alu_req.b = res_q + bitv;
			end
			ST_GMUL: begin
				mul_a = 25'($signed({1'b0, ms_q}));
				mul_b = 33'(gyr_q[axis_q]);
			end
			ST_DIV: begin
				alu_req.a = ALU_W'(r2);
				alu_req.b = ALU_W'(gyro_divisor(grange_q));
			end
			ST_BLEND: begin
				case (cnt_q)
					CW'(0): begin
						mul_a = 25'($signed({1'b0, alpha_q}));
						mul_b = 33'(pred_q[0]);
					end
					CW'(1): begin
						// 65536 - alpha, kept positive when alpha is zero
						mul_a = 25'(18'h10000 - {2'b0, alpha_q});
						mul_b = 33'(roll_q);
						acc_clr = 1'b0;
					end
					CW'(2): begin
						mul_a = 25'($signed({1'b0, alpha_q}));
						mul_b = 33'(pred_q[1]);
					end
					CW'(3): begin
						mul_a = 25'(18'h10000 - {2'b0, alpha_q});
						mul_b = 33'(pitch_q);
						acc_clr = 1'b0;
					end
					CW'(4): begin
						mul_a = 25'($signed({1'b0, YAW_KEEP}));
						mul_b = 33'(pred_q[2]);
					end
					CW'(5): begin
						mul_a = 25'($signed({1'b0, YAW_REST}));
						mul_b = 33'(held_q);
						acc_clr = 1'b0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			ang_q      <= ANG_ROLL;
			axis_q     <= '0;
			alpha_q    <= ALPHA_RESET;
			grange_q   <= RANGE_RESET;
			m_tvalid_q <= 1'b0;
			held_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				integ_q[i] <= '0;
				fused_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CW'(1);

			if (cfg_we) begin
				unique case (cfg_index)
					REG_ALPHA: alpha_q  <= cfg_wdata;
					REG_RANGE: grange_q <= cfg_wdata[1:0];
					default: ;
				endcase
			end

			if (state_q == ST_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					ang_q  <= ANG_ROLL;
					axis_q <= '0;
				end
				ST_ROOT_LD: begin
					if (skip) begin
						if (ang_q == ANG_YAW)
							axis_q <= '0;
						ang_q <= (ang_q == ANG_ROLL) ? ANG_PITCH : ANG_YAW;
					end
				end
				ST_CORD_LD: begin
					if (y_zero) begin
						if (ang_q == ANG_YAW)
							held_q <= '0;
						ang_q <= (ang_q == ANG_ROLL) ? ANG_PITCH : ANG_YAW;
					end
				end
				ST_CORD: begin
					if (cnt_q == CORD_LAST) begin
						if (ang_q == ANG_YAW)
							held_q <= z_rnd[31:0];
						ang_q <= (ang_q == ANG_ROLL) ? ANG_PITCH : ANG_YAW;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						integ_q[axis_q] <= sat32(SW'(integ_q[axis_q]) + SW'(dx));
						axis_q <= axis_q + 2'd1;
					end
				end
				ST_BLEND: begin
					case (cnt_q)
						CW'(2): fused_q[0] <= rnd16[47:16];
						CW'(4): fused_q[1] <= rnd16[47:16];
						CW'(6): fused_q[2] <= yaw_new;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					acc_in_q[0] <= s_tdata[15:0];
					acc_in_q[1] <= s_tdata[31:16];
					acc_in_q[2] <= s_tdata[47:32];
					gyr_q[0]    <= s_tdata[63:48];
					gyr_q[1]    <= s_tdata[79:64];
					gyr_q[2]    <= s_tdata[95:80];
					ms_q        <= s_tdata[111:96];
					valid_q     <= $signed(s_tdata[47:32]) > 16'sd0;
				end
			end
			ST_SQR: sq_q[cnt_q[1:0]] <= prod[30:0];
			ST_ROOT_LD: begin
				n_q   <= {s_sel[31:0], 30'd0};
				res_q <= '0;
				if (skip) begin
					if (ang_q == ANG_ROLL)
						roll_q <= '0;
					else if (ang_q == ANG_PITCH)
						pitch_q <= '0;
				end
			end
			ST_ROOT: begin
				if (alu_res.ge) begin
					n_q   <= alu_res.diff[61:0];
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			ST_CORD_LD: begin
				x_q <= xi;
				y_q <= yi;
				z_q <= '0;
				if (y_zero) begin
					if (ang_q == ANG_ROLL)
						roll_q <= '0;
					else if (ang_q == ANG_PITCH)
						pitch_q <= '0;
				end
			end
			ST_CORD: begin
				// rotate toward the x axis, sign of y picks the direction
				if (!y_q[XW-1]) begin
					x_q <= x_q + x_sh;
					y_q <= y_q - y_sh;
				end else begin
					x_q <= x_q - x_sh;
					y_q <= y_q + y_sh;
				end
				z_q <= z_nxt;
				if (cnt_q == CORD_LAST) begin
					if (ang_q == ANG_ROLL)
						roll_q <= z_rnd[31:0];
					else if (ang_q == ANG_PITCH)
						pitch_q <= z_rnd[31:0];
				end
			end
			ST_GMUL: p_q <= prod[32:0];
			ST_DIV_LD: begin
				// magnitude scaled by 2^F plus half the divisor, rounds half away from zero
				num_q <= (NW'(mag) << F) + NW'(gyro_divisor(grange_q) >> 1);
				neg_q <= p_q[32];
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				quo_q <= q_fin;
				rem_q <= alu_res.ge ? alu_res.diff[17:0] : r2;
				if (cnt_q == DIV_LAST)
					pred_q[axis_q] <= sat32(SW'(fused_q[axis_q]) + SW'(dx));
			end
			ST_BLEND: acc_q <= acc_clr ? 60'(prod) : acc_q + 60'(prod);
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {7'd0, held_q[23:0], pitch_q[24:0], roll_q[23:0],
						integ_q[2], integ_q[1], integ_q[0],
						fused_q[2], fused_q[1], fused_q[0]};
					m_tuser_q <= valid_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

@@ tb/sv/tb_imu_tilt_complementary_filter.sv @@
module tb_imu_tilt_complementary_filter;
	import itcf_pkg::*;

	localparam int FRAC       = 16;
	localparam int STEPS      = 20;
	localparam int STALL_MAX  = 20000;
	localparam int TAIL_WAIT  = 400;

	typedef struct {
		shortint     ax, ay, az;
		shortint     gx, gy, gz;
		logic [15:0] ms;
	} sample_t;

	typedef struct {
		int          fused_r, fused_p, fused_y;
		int          gyro_r, gyro_p, gyro_y;
		logic [23:0] tilt_r;
		logic [24:0] tilt_p;
		logic [23:0] tilt_y;
		logic        yaw_ok;
	} angles_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [271:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [15:0]  cfg_wdata;

	imu_tilt_complementary_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// filter state mirrored by the predictor
	logic [15:0] alpha_q16;
	logic [1:0]  range_sel;
	int          integ_x, integ_y, integ_z;
	int          fused_x, fused_y, fused_z;
	int          held_yaw;

	angles_t     pending_angles[$];
	int          errors;
	bit          send_quiet;
	bit          recv_quiet;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_ALPHA;
		cfg_wdata = '0;
	end

	// ---------------- predictor ----------------

	function automatic longint atan_step_q32(int i);
		longint unsigned deg_rad;
		longint          acc;
		int              n;
		int              sh;
		deg_rad = 64'd246083499208;
		if (i == 0)
			return 64'sd193273528320;
		if (i == 1)
			return 64'sd114096026022;
		acc = 0;
		for (int k = 0; k < 32; k++) begin
			n  = 2 * k + 1;
			sh = i * n;
			if (sh >= 64)
				break;
			if (k % 2 == 1)
				acc -= longint'((deg_rad >> sh) / longint'(n));
			else
				acc += longint'((deg_rad >> sh) / longint'(n));
		end
		return acc;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res;
		longint unsigned bit_w;
		res   = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > n)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (n >= res + bit_w) begin
				n   -= res + bit_w;
				res  = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	function automatic longint root_scaled(longint s);
		return longint'(int_root(longint'(s) << 30));
	endfunction

	// atan2(y, x) for x > 0, degrees with FRAC fraction bits
	function automatic int cordic_angle(longint x, longint y);
		longint z;
		longint dx;
		longint dy;
		longint a;
		if (y == 0)
			return 0;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			a  = atan_step_q32(i);
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += a;
			end else begin
				x -= dx;
				y += dy;
				z -= a;
			end
		end
		z += longint'(1) << (31 - FRAC);
		return int'(z >>> (32 - FRAC));
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint rate_step(longint rate, longint ms);
		longint unsigned d;
		longint          p;
		longint unsigned mag;
		longint unsigned q;
		case (range_sel)
			2'd0:    d = 131000;
			2'd1:    d = 65500;
			2'd2:    d = 32800;
			default: d = 16400;
		endcase
		p   = rate * ms;
		mag = (p < 0) ? longint'(-p) : longint'(p);
		q   = ((mag << FRAC) + d / 2) / d;
		return (p < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic int alpha_blend(int pred, int tilt);
		longint a;
		longint s;
		a = longint'(alpha_q16);
		s = a * longint'(pred) + (65536 - a) * longint'(tilt) + 32768;
		return int'(s >>> 16);
	endfunction

	function automatic angles_t filter_update(sample_t smp);
		angles_t r;
		longint  ax, ay, az, gx, gy, gz, ms;
		longint  sxz, syz, sxy;
		longint  dx, dy, dz;
		longint  s;
		int      roll, pitch, px, py, pz;
		bit      yaw_ok;
		ax = smp.ax;
		ay = smp.ay;
		az = smp.az;
		gx = smp.gx;
		gy = smp.gy;
		gz = smp.gz;
		ms = longint'(smp.ms);
		sxz = ax * ax + az * az;
		syz = ay * ay + az * az;
		sxy = ax * ax + ay * ay;
		roll   = 0;
		pitch  = 0;
		yaw_ok = az > 0;
		if (sxz != 0)
			roll = cordic_angle(root_scaled(sxz), ay * 32768);
		if (syz != 0)
			pitch = cordic_angle(root_scaled(syz), -ax * 32768);
		if (yaw_ok)
			held_yaw = cordic_angle(az * 32768, root_scaled(sxy));

		dx = rate_step(gx, ms);
		dy = rate_step(gy, ms);
		dz = rate_step(gz, ms);
		integ_x = clamp32(longint'(integ_x) + dx);
		integ_y = clamp32(longint'(integ_y) + dy);
		integ_z = clamp32(longint'(integ_z) + dz);
		px = clamp32(longint'(fused_x) + dx);
		py = clamp32(longint'(fused_y) + dy);
		pz = clamp32(longint'(fused_z) + dz);

		fused_x = alpha_blend(px, roll);
		fused_y = alpha_blend(py, pitch);
		if (yaw_ok) begin
			s = longint'(YAW_KEEP) * longint'(pz) + longint'(YAW_REST) * longint'(held_yaw)
				+ (longint'(1) << 23);
			fused_z = int'(s >>> 24);
		end else if (fused_z > pz) begin
			// nudge 0.001 deg toward the old fused yaw
			fused_z = clamp32(longint'(pz) + ((longint'(1) << FRAC) + 500) / 1000);
		end else if (fused_z < pz) begin
			fused_z = clamp32(longint'(pz) - ((longint'(1) << FRAC) + 500) / 1000);
		end

		r.fused_r = fused_x;
		r.fused_p = fused_y;
		r.fused_y = fused_z;
		r.gyro_r  = integ_x;
		r.gyro_p  = integ_y;
		r.gyro_y  = integ_z;
		r.tilt_r  = roll[23:0];
		r.tilt_p  = pitch[24:0];
		r.tilt_y  = held_yaw[23:0];
		r.yaw_ok  = yaw_ok;
		return r;
	endfunction

	// ---------------- drivers ----------------

	// entered and left at a falling edge
	task automatic send_sample(sample_t smp);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {smp.ms, smp.gz, smp.gy, smp.gx, smp.az, smp.ay, smp.ax};
		do
			@(posedge clk);
		while (!s_tready);
		pending_angles.push_back(filter_update(smp));
		@(negedge clk);
	endtask

	task automatic send_raw(int ax, int ay, int az, int gx, int gy, int gz, int ms);
		sample_t smp;
		smp.ax = 16'(ax);
		smp.ay = 16'(ay);
		smp.az = 16'(az);
		smp.gx = 16'(gx);
		smp.gy = 16'(gy);
		smp.gz = 16'(gz);
		smp.ms = 16'(ms);
		send_sample(smp);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_angles.size() != 0)
			@(negedge clk);
	endtask

	// only called with the block idle
	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_ALPHA)
			alpha_q16 = val;
		else
			range_sel = val[1:0];
	endtask

	// result side: random stall per transfer, quiet stretches hold ready high
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = recv_quiet ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			if ($urandom_range(0, 39) == 0)
				recv_quiet = !recv_quiet;
		end
	end

	// ---------------- checking ----------------

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		angles_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_angles.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_angles.pop_front();
				check_field("fused_roll",  e.fused_r,  m_tdata[31:0]);
				check_field("fused_pitch", e.fused_p,  m_tdata[63:32]);
				check_field("fused_yaw",   e.fused_y,  m_tdata[95:64]);
				check_field("gyro_roll",   e.gyro_r,   m_tdata[127:96]);
				check_field("gyro_pitch",  e.gyro_p,   m_tdata[159:128]);
				check_field("gyro_yaw",    e.gyro_y,   m_tdata[191:160]);
				check_field("tilt_roll",   32'(e.tilt_r), 32'(m_tdata[215:192]));
				check_field("tilt_pitch",  32'(e.tilt_p), 32'(m_tdata[240:216]));
				check_field("tilt_yaw",    32'(e.tilt_y), 32'(m_tdata[264:241]));
				check_field("yaw_valid",   32'(e.yaw_ok), 32'(m_tuser[0]));
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_MAX) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_extremes();
		send_raw(0, 0, 0, 0, 0, 0, 0);
		send_raw(32767, 32767, 32767, 32767, 32767, 32767, 65535);
		send_raw(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
		send_raw(-32768, 32767, 1, 1, -1, 0, 1);
		send_raw(32767, -32768, -1, -32768, 32767, -32768, 65535);
		send_raw(1, -1, 32767, 0, 0, 0, 1);
		drain_results();
	endtask

	task automatic test_zero_roots();
		// ax = az = 0 kills the roll root, ay = az = 0 kills pitch
		send_raw(0, 12000, 0, 100, -100, 50, 10);
		send_raw(-9000, 0, 0, -50, 100, -100, 10);
		// level sensor: yaw numerator is zero
		send_raw(0, 0, 16384, 0, 0, 0, 5);
		send_raw(0, 0, -16384, 0, 0, 0, 5);
		drain_results();
	endtask

	task automatic test_invalid_yaw();
		// spin yaw one way, then flip az so yaw is nudged from both sides
		send_raw(100, 200, 16384, 0, 0, 3000, 20);
		send_raw(100, 200, -16384, 0, 0, 3000, 20);
		send_raw(100, 200, 0, 0, 0, -3000, 20);
		send_raw(100, 200, -1, 0, 0, -9000, 50);
		send_raw(100, 200, -300, 0, 0, 0, 0);
		send_raw(-32768, 0, -32768, 0, 0, 0, 1);
		drain_results();
	endtask

	task automatic test_saturation();
		write_reg(REG_RANGE, 16'd3);
		send_raw(0, 0, 100, 32767, 32767, 32767, 65535);
		send_raw(0, 0, -100, 32767, 32767, 32767, 65535);
		send_raw(0, 0, 100, -32768, -32768, -32768, 65535);
		send_raw(0, 0, -100, -32768, -32768, -32768, 65535);
		send_raw(0, 0, -100, -32768, -32768, -32768, 65535);
		send_raw(0, 0, 100, 20000, -20000, 20000, 65535);
		drain_results();
		write_reg(REG_RANGE, 16'd0);
	endtask

	function automatic sample_t pick_sample();
		sample_t smp;
		int      mode;
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			// gravity-like vector with noise, small time step
			smp.ax = 16'(int'($urandom_range(0, 32767)) - 16384);
			smp.ay = 16'(int'($urandom_range(0, 32767)) - 16384);
			smp.az = $urandom_range(0, 3) == 0 ? 16'(-int'($urandom_range(0, 20000)))
				: 16'($urandom_range(0, 20000));
			smp.gx = 16'(int'($urandom_range(0, 8000)) - 4000);
			smp.gy = 16'(int'($urandom_range(0, 8000)) - 4000);
			smp.gz = 16'(int'($urandom_range(0, 8000)) - 4000);
			smp.ms = 16'($urandom_range(0, 25));
		end else begin
			smp.ax = 16'($urandom);
			smp.ay = 16'($urandom);
			smp.az = 16'($urandom);
			smp.gx = 16'($urandom);
			smp.gy = 16'($urandom);
			smp.gz = 16'($urandom);
			smp.ms = mode == 9 ? 16'($urandom) : 16'($urandom_range(0, 1000));
		end
		return smp;
	endfunction

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				send_quiet = $urandom_range(0, 3) == 0;
			send_sample(pick_sample());
		end
		send_quiet = 1'b0;
		drain_results();
	endtask

	task automatic test_config_sweep();
		logic [15:0] alphas[6];
		alphas = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd64225, 16'd0};
		alphas[5] = 16'($urandom);
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_ALPHA, alphas[p]);
			write_reg(REG_RANGE, 16'(p % 4));
			test_random(213);
		end
	endtask

	initial begin
		errors     = 0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		alpha_q16  = ALPHA_RESET;
		range_sel  = RANGE_RESET;
		integ_x = 0;
		integ_y = 0;
		integ_z = 0;
		fused_x = 0;
		fused_y = 0;
		fused_z = 0;
		held_yaw = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extremes();
		test_zero_roots();
		test_invalid_yaw();
		test_saturation();
		test_config_sweep();

		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0 && pending_angles.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (pending_angles.size() != 0)
				$error("%0d expected results never arrived", pending_angles.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/itcf_pkg.sv
design/itcf_addsub.sv
design/imu_tilt_complementary_filter.sv
tb/sv/tb_imu_tilt_complementary_filter.sv
